>>> hdl/bpr_pkg.sv
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared codes for the buffer pool page replacement engine: request
// functions, result status codes and controller states.
// ----------------------------------------------------------------------------
package bpr_pkg;

  typedef enum logic {
    FUNC_GET     = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    STATUS_HIT        = 3'd0,
    STATUS_MISS_READ  = 3'd1,
    STATUS_MISS_NEW   = 3'd2,
    STATUS_BEYOND     = 3'd3,
    STATUS_ALL_PINNED = 3'd4,
    STATUS_RELEASED   = 3'd5,
    STATUS_NOT_FOUND  = 3'd6
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_FILL   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned REQ_AW   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned UCNT_W   = 4;
  localparam int unsigned UCNT_MAX = 15;

endpackage

>>> hdl/bpr_req_if.sv
// ----------------------------------------------------------------------------
// bpr_req_if
// Request channel: valid/ready handshake carrying one get or release request.
// ----------------------------------------------------------------------------
interface bpr_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] addr;
  logic [31:0] file_length;

  modport source (output valid, output func, output addr, output file_length, input ready);
  modport sink   (input valid, input func, input addr, input file_length, output ready);
endinterface

>>> hdl/bpr_rsp_if.sv
// ----------------------------------------------------------------------------
// bpr_rsp_if
// Result channel: valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface bpr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic        writeback;
  logic [31:0] writeback_addr;
  logic [3:0]  unpinned_count;

  modport source (output valid, output status, output slot, output writeback,
                  output writeback_addr, output unpinned_count, input ready);
  modport sink   (input valid, input status, input slot, input writeback,
                  input writeback_addr, input unpinned_count, output ready);
endinterface

>>> hdl/buffer_pool_page_replacement.sv
// ----------------------------------------------------------------------------
// buffer_pool_page_replacement
// Tag and policy engine for a pinned LRU page buffer pool.
// ----------------------------------------------------------------------------
// The slot records sit in a ring of SLOTS cells that rotates one place per
// cycle, while the engine scans or fills, past a single head unit, which does
// the lookup, aging, release and victim tracking for the record passing it.
// A request is taken only while the engine is idle. A release, a hit, a
// beyond-end or an all-pinned get takes one full rotation plus the accept,
// decision and hand-off states; a get that fills a slot takes a second
// rotation to write it. A finished result waits in the output register, so
// the next request can be scanned while it is still untaken.
module buffer_pool_page_replacement #(
  parameter int SLOTS     = 8,
  parameter int AGE_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  bpr_req_if.sink    req_i,
  bpr_rsp_if.source  rsp_o
);

  import bpr_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(SLOTS - 1);
  localparam logic [AGE_BITS-1:0] AGE_ONE  = AGE_BITS'(1);
  localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;

  // ring of slot records
  logic [ADDR_BITS-1:0] c_addr   [SLOTS];
  logic                 c_valid  [SLOTS];
  logic [AGE_BITS-1:0]  c_age    [SLOTS];
  logic                 c_pinned [SLOTS];
  logic [ADDR_BITS-1:0] i_addr   [SLOTS];
  logic                 i_valid  [SLOTS];
  logic [AGE_BITS-1:0]  i_age    [SLOTS];
  logic                 i_pinned [SLOTS];

  logic [ADDR_BITS-1:0] n_addr;
  logic                 n_valid;
  logic [AGE_BITS-1:0]  n_age;
  logic                 n_pinned;
  logic                 shift;

  for (genvar g = 0; g < SLOTS; g++) begin : g_ring
    if (g == 0) begin : g_head
      assign i_addr[g]   = n_addr;
      assign i_valid[g]  = n_valid;
      assign i_age[g]    = n_age;
      assign i_pinned[g] = n_pinned;
    end else begin : g_link
      assign i_addr[g]   = c_addr[g-1];
      assign i_valid[g]  = c_valid[g-1];
      assign i_age[g]    = c_age[g-1];
      assign i_pinned[g] = c_pinned[g-1];
    end
    bpr_cell #(
      .AGE_BITS  (AGE_BITS),
      .ADDR_BITS (ADDR_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .addr_i   (i_addr[g]),
      .valid_i  (i_valid[g]),
      .age_i    (i_age[g]),
      .pinned_i (i_pinned[g]),
      .addr_o   (c_addr[g]),
      .valid_o  (c_valid[g]),
      .age_o    (c_age[g]),
      .pinned_o (c_pinned[g])
    );
  end

  // control
  state_e               state_q, state_d;
  logic [IDX_W-1:0]     idx_q;
  logic                 rsp_valid_q;
  logic                 out_free;

  // request under work
  logic                 func_q;
  logic [ADDR_BITS-1:0] a_q;
  logic [ADDR_BITS-1:0] len_q;
  logic                 beyond_q;

  // scan trackers
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic                 empty_q;
  logic [IDX_W-1:0]     empty_idx_q;
  logic                 best_found_q;
  logic [AGE_BITS-1:0]  best_age_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [ADDR_BITS-1:0] best_addr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     victim_q;

  // finished result
  status_e              res_status_q;
  logic [IDX_W-1:0]     res_slot_q;
  logic                 res_wb_q;
  logic [ADDR_BITS-1:0] res_wb_addr_q;

  // output register
  logic [STATUS_W-1:0]  rsp_status_q;
  logic [SLOT_W-1:0]    rsp_slot_q;
  logic                 rsp_wb_q;
  logic [REQ_AW-1:0]    rsp_wb_addr_q;
  logic [UCNT_W-1:0]    rsp_cnt_q;

  logic [ADDR_BITS-1:0] h_addr;
  logic                 h_valid;
  logic [AGE_BITS-1:0]  h_age;
  logic                 h_pinned;
  logic                 h_match;
  logic                 get_live;
  logic                 req_fire;

  assign h_addr   = c_addr[SLOTS-1];
  assign h_valid  = c_valid[SLOTS-1];
  assign h_age    = c_age[SLOTS-1];
  assign h_pinned = c_pinned[SLOTS-1];
  assign h_match  = h_valid && (h_addr == a_q);
  assign get_live = (func_q == FUNC_GET) && !beyond_q;

  assign shift     = (state_q == ST_SCAN) || (state_q == ST_FILL);
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire  = req_i.valid && req_i.ready;
  assign out_free  = !rsp_valid_q || rsp_o.ready;

  // head unit: updates the record leaving the last cell
  always_comb begin
    n_addr   = h_addr;
    n_valid  = h_valid;
    n_age    = h_age;
    n_pinned = h_pinned;
    if (state_q == ST_SCAN) begin
      if (get_live) begin
        if (h_match) begin
          n_age    = AGE_ONE;
          n_pinned = 1'b1;
        end else if (h_age != AGE_MAX) begin
          n_age = h_age + AGE_ONE;
        end
      end else if (func_q == FUNC_RELEASE && h_match) begin
        n_pinned = 1'b0;
      end
    end else if (state_q == ST_FILL && idx_q == victim_q) begin
      n_addr   = a_q;
      n_valid  = 1'b1;
      n_age    = AGE_ONE;
      n_pinned = 1'b1;
    end
  end

  // decision after the lookup rotation
  status_e          dec_status;
  logic [IDX_W-1:0] dec_slot;
  logic             dec_fill;
  logic             dec_wb;
  status_e          fill_status;

  assign fill_status = (a_q == len_q) ? STATUS_MISS_NEW : STATUS_MISS_READ;

  always_comb begin
    dec_status = STATUS_NOT_FOUND;
    dec_slot   = '0;
    dec_fill   = 1'b0;
    dec_wb     = 1'b0;
    priority if (func_q == FUNC_RELEASE) begin
      dec_status = hit_q ? STATUS_RELEASED : STATUS_NOT_FOUND;
      dec_slot   = hit_q ? hit_idx_q : '0;
    end else if (beyond_q) begin
      dec_status = STATUS_BEYOND;
    end else if (hit_q) begin
      dec_status = STATUS_HIT;
      dec_slot   = hit_idx_q;
    end else if (empty_q) begin
      dec_status = fill_status;
      dec_slot   = empty_idx_q;
      dec_fill   = 1'b1;
    end else if (best_found_q) begin
      dec_status = fill_status;
      dec_slot   = best_idx_q;
      dec_fill   = 1'b1;
      dec_wb     = 1'b1;
    end else begin
      dec_status = STATUS_ALL_PINNED;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_fire) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == '0) state_d = ST_DECIDE;
      ST_DECIDE: state_d = dec_fill ? ST_FILL : ST_FINISH;
      ST_FILL:   if (idx_q == '0) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= IDX_LAST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_fire || state_q == ST_DECIDE) begin
        idx_q <= IDX_LAST;
      end else if (shift) begin
        idx_q <= idx_q - IDX_W'(1);
      end
      if (state_q == ST_FINISH && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // slots pass the head in descending index order, so the last empty or
  // oldest-on-tie record seen is the lowest index
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q       <= req_i.func;
      a_q          <= ADDR_BITS'(req_i.addr);
      len_q        <= ADDR_BITS'(req_i.file_length);
      beyond_q     <= ADDR_BITS'(req_i.addr) > ADDR_BITS'(req_i.file_length);
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      empty_q      <= 1'b0;
      empty_idx_q  <= '0;
      best_found_q <= 1'b0;
      best_age_q   <= '0;
      best_idx_q   <= '0;
      best_addr_q  <= '0;
      cnt_q        <= '0;
    end else if (state_q == ST_SCAN) begin
      if (h_match && (get_live || func_q == FUNC_RELEASE)) begin
        hit_q     <= 1'b1;
        hit_idx_q <= idx_q;
      end
      if (!h_valid) begin
        empty_q     <= 1'b1;
        empty_idx_q <= idx_q;
      end
      if (!n_pinned && (!best_found_q || n_age >= best_age_q)) begin
        best_found_q <= 1'b1;
        best_age_q   <= n_age;
        best_idx_q   <= idx_q;
        best_addr_q  <= h_addr;
      end
      cnt_q <= cnt_q + CNT_W'(!n_pinned);
    end else if (state_q == ST_DECIDE) begin
      // the victim was unpinned before the fill
      cnt_q         <= cnt_q - CNT_W'(dec_fill);
      victim_q      <= dec_slot;
      res_status_q  <= dec_status;
      res_slot_q    <= dec_slot;
      res_wb_q      <= dec_wb;
      res_wb_addr_q <= dec_wb ? best_addr_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      rsp_status_q  <= res_status_q;
      rsp_slot_q    <= SLOT_W'(res_slot_q);
      rsp_wb_q      <= res_wb_q;
      rsp_wb_addr_q <= REQ_AW'(res_wb_addr_q);
      rsp_cnt_q     <= (32'(cnt_q) > UCNT_MAX) ? UCNT_W'(UCNT_MAX) : UCNT_W'(cnt_q);
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.slot           = rsp_slot_q;
  assign rsp_o.writeback      = rsp_wb_q;
  assign rsp_o.writeback_addr = rsp_wb_addr_q;
  assign rsp_o.unpinned_count = rsp_cnt_q;

  // the lookup rotation ends after exactly one pass over the ring
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && idx_q == '0) |=> (state_q == ST_DECIDE))
    else $error("lookup rotation did not end at slot zero");

  // a fill pass follows only a get that missed
  a_fill_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && dec_fill) |-> (func_q == FUNC_GET && !hit_q && !beyond_q))
    else $error("fill started for a request that was not a get miss");

  // unpinned count never exceeds the pool size at hand-off
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (32'(cnt_q) <= SLOTS))
    else $error("unpinned count out of range");

  // a write-back only comes with a miss that evicted a page
  a_wb_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && dec_wb) |->
      (dec_status == STATUS_MISS_READ || dec_status == STATUS_MISS_NEW))
    else $error("write-back reported without an eviction");

endmodule

>>> hdl/bpr_cell.sv
// ----------------------------------------------------------------------------
// bpr_cell
// One slot record of the tag ring: page address, valid, age and pin mark.
// On shift the record moves on to the next cell of the ring.
// ----------------------------------------------------------------------------
module bpr_cell #(
  parameter int AGE_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic                 valid_i,
  input  logic [AGE_BITS-1:0]  age_i,
  input  logic                 pinned_i,
  output logic [ADDR_BITS-1:0] addr_o,
  output logic                 valid_o,
  output logic [AGE_BITS-1:0]  age_o,
  output logic                 pinned_o
);

  logic [ADDR_BITS-1:0] addr_q;
  logic                 valid_q;
  logic [AGE_BITS-1:0]  age_q;
  logic                 pinned_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      valid_q  <= 1'b0;
      age_q    <= AGE_BITS'(1);
      pinned_q <= 1'b0;
    end else if (shift_i) begin
      addr_q   <= addr_i;
      valid_q  <= valid_i;
      age_q    <= age_i;
      pinned_q <= pinned_i;
    end
  end

  assign addr_o   = addr_q;
  assign valid_o  = valid_q;
  assign age_o    = age_q;
  assign pinned_o = pinned_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buffer pool page replacement engine. Directed
// get/release sequences, random page traffic and an eviction order run are
// driven through the request channel; a tag store predictor computes each
// expected result at acceptance and a result monitor checks every field.
// ----------------------------------------------------------------------------
module testbench;
  import bpr_pkg::*;

  localparam int          SLOTS          = 8;
  localparam logic [15:0] AGE_MAX        = 16'hFFFF;
  localparam int          LATENCY        = 2 * SLOTS + 3;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic        writeback;
    logic [31:0] writeback_addr;
    logic [3:0]  unpinned_count;
  } page_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #4 clk_i = ~clk_i;

  bpr_req_if req_if ();
  bpr_rsp_if rsp_if ();

  buffer_pool_page_replacement dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predicted tag store
  logic [31:0] tag_addr   [SLOTS];
  logic        tag_valid  [SLOTS];
  logic [15:0] tag_age    [SLOTS];
  logic        tag_pinned [SLOTS];

  page_result_t expected_results[$];
  int           mismatch_count = 0;
  int           idle_cycles    = 0;
  int           req_gap        = 0;
  bit           req_high       = 1'b0;
  bit           burst_mode     = 1'b0;

  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic page_result_t predict_page_access(func_e f, logic [31:0] a,
                                                       logic [31:0] len);
    page_result_t r;
    int           k;
    bit           found;
    logic [15:0]  best;
    int           unpinned;
    r.status         = STATUS_NOT_FOUND;
    r.slot           = 3'd0;
    r.writeback      = 1'b0;
    r.writeback_addr = 32'd0;
    k                = -1;
    if (f == FUNC_GET) begin
      if (a > len) begin
        r.status = STATUS_BEYOND;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tag_valid[i] && tag_addr[i] == a) begin
            k             = i;
            tag_age[i]    = 16'd1;
            tag_pinned[i] = 1'b1;
          end else if (tag_age[i] != AGE_MAX) begin
            tag_age[i] = tag_age[i] + 16'd1;
          end
        end
        if (k >= 0) begin
          r.status = STATUS_HIT;
          r.slot   = k[2:0];
        end else begin
          for (int i = 0; i < SLOTS && k < 0; i++)
            if (!tag_valid[i]) k = i;
          if (k < 0) begin
            found = 1'b0;
            best  = '0;
            for (int i = 0; i < SLOTS; i++) begin
              if (!tag_pinned[i] && (!found || tag_age[i] > best)) begin
                best  = tag_age[i];
                k     = i;
                found = 1'b1;
              end
            end
            if (k >= 0) begin
              r.writeback      = 1'b1;
              r.writeback_addr = tag_addr[k];
            end
          end
          if (k >= 0) begin
            tag_age[k]    = 16'd1;
            tag_pinned[k] = 1'b1;
            tag_valid[k]  = 1'b1;
            tag_addr[k]   = a;
            r.status      = (a == len) ? STATUS_MISS_NEW : STATUS_MISS_READ;
            r.slot        = k[2:0];
          end else begin
            r.status = STATUS_ALL_PINNED;
          end
        end
      end
    end else begin
      for (int i = 0; i < SLOTS && k < 0; i++)
        if (tag_valid[i] && tag_addr[i] == a) k = i;
      if (k >= 0) begin
        tag_pinned[k] = 1'b0;
        r.status      = STATUS_RELEASED;
        r.slot        = k[2:0];
      end
    end
    unpinned = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!tag_pinned[i]) unpinned++;
    r.unpinned_count = (unpinned > UCNT_MAX) ? 4'(UCNT_MAX) : 4'(unpinned);
    return r;
  endfunction

  // valid stays high into the next request when the drawn gap is zero
  task automatic send_request(func_e f, logic [31:0] a, logic [31:0] len);
    if (req_gap > 0) repeat (req_gap) @(posedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.func        <= f;
    req_if.addr        <= a;
    req_if.file_length <= len;
    req_high = 1'b1;
    do @(posedge clk_i); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
    expected_results.push_back(predict_page_access(f, a, len));
    req_gap = draw_gap();
    if (req_gap > 0) begin
      req_if.valid <= 1'b0;
      req_high = 1'b0;
    end
  endtask

  task automatic drain_engine();
    if (req_high) begin
      req_if.valid <= 1'b0;
      req_high = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic test_directed_paths();
    burst_mode = 1'b0;
    send_request(FUNC_GET, 32'd5, 32'd0);                     // beyond end, empty pool
    send_request(FUNC_RELEASE, 32'd0, 32'd0);                 // empty slots do not match
    send_request(FUNC_GET, 32'd0, 32'd0);                     // new page at offset 0
    send_request(FUNC_GET, 32'd0, 32'hFFFF_FFFF);             // hit
    send_request(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // new page at the top
    send_request(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFE);     // beyond by one
    for (int i = 1; i <= 6; i++)
      send_request(FUNC_GET, i * 32'h2000_0001, 32'hFFFF_FFFF);
    send_request(FUNC_GET, 32'd7, 32'd7);                     // every slot pinned
    send_request(FUNC_RELEASE, 32'h4000_0002, 32'd0);
    send_request(FUNC_RELEASE, 32'h2000_0001, 32'hFFFF_FFFF);
    send_request(FUNC_GET, 32'd7, 32'h100);                   // evict oldest unpinned
    send_request(FUNC_RELEASE, 32'd7, 32'd0);
    send_request(FUNC_RELEASE, 32'h4000_0002, 32'd0);         // already unpinned
    send_request(FUNC_GET, 32'h4000_0002, 32'hFFFF_FFFF);     // hit repins
    send_request(FUNC_RELEASE, 32'hDEAD_BEEF, 32'd0);         // not held
    send_request(FUNC_RELEASE, 32'd0, 32'd0);
    send_request(FUNC_RELEASE, 32'hFFFF_FFFF, 32'd0);
    send_request(FUNC_GET, 32'h8000_0000, 32'h7FFF_FFFF);     // beyond, pool full
    drain_engine();
  endtask

  task automatic test_random_traffic(int n_items);
    logic [31:0] hot_pages [12];
    logic [31:0] pinned_pages[$];
    logic [31:0] a;
    logic [31:0] len;
    logic [31:0] span;
    int          pick;
    foreach (hot_pages[i]) hot_pages[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) hot_pages[$urandom_range(0, 11)] = $urandom;
      if ($urandom_range(0, 99) < 55) begin
        a    = ($urandom_range(0, 99) < 85) ? hot_pages[$urandom_range(0, 11)] : $urandom;
        pick = $urandom_range(0, 9);
        span = ~a;
        if (pick < 6)
          len = a + ((span == 32'hFFFF_FFFF) ? $urandom : $urandom % (span + 32'd1));
        else if (pick < 8)
          len = a;
        else
          len = $urandom;
        send_request(FUNC_GET, a, len);
      end else begin
        pinned_pages.delete();
        for (int i = 0; i < SLOTS; i++)
          if (tag_valid[i] && tag_pinned[i]) pinned_pages.push_back(tag_addr[i]);
        pick = $urandom_range(0, 99);
        if (pick < 75 && pinned_pages.size() != 0)
          a = pinned_pages[$urandom_range(0, pinned_pages.size() - 1)];
        else if (pick < 90)
          a = hot_pages[$urandom_range(0, 11)];
        else
          a = $urandom;
        send_request(FUNC_RELEASE, a, $urandom);
      end
    end
    burst_mode = 1'b0;
    drain_engine();
  endtask

  // A hot page stays pinned while the others age; the next miss evicts the
  // oldest unpinned page, not the one released last.
  task automatic test_eviction_order();
    logic [31:0] fresh;
    bit          held;
    burst_mode = 1'b1;
    for (int i = 0; i < SLOTS; i++)
      if (tag_valid[i] && tag_pinned[i]) send_request(FUNC_RELEASE, tag_addr[i], 32'd0);
    for (int i = 0; i <= SLOTS; i++) begin
      do begin
        fresh = $urandom;
        held  = 1'b0;
        for (int j = 0; j < SLOTS; j++) held |= tag_valid[j] && tag_addr[j] == fresh;
      end while (held);
      if (i == SLOTS) begin
        // pool now holds fresh pages only: unpin all, then make slot 1 the youngest
        for (int j = 0; j < SLOTS; j++) send_request(FUNC_RELEASE, tag_addr[j], 32'd0);
        send_request(FUNC_GET, tag_addr[1], 32'hFFFF_FFFF);
        send_request(FUNC_RELEASE, tag_addr[1], 32'd0);
        repeat (16) send_request(FUNC_GET, tag_addr[0], 32'hFFFF_FFFF);
      end
      send_request(FUNC_GET, fresh, 32'hFFFF_FFFF);
    end
    send_request(FUNC_RELEASE, tag_addr[0], 32'd0);
    burst_mode = 1'b0;
    drain_engine();
  endtask

  // result monitor
  initial begin : result_monitor
    page_result_t exp;
    int           stall;
    bit           bad;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status=%0d slot=%0d", rsp_if.status, rsp_if.slot);
      end else begin
        exp = expected_results.pop_front();
        bad = (rsp_if.status !== exp.status) || (rsp_if.slot !== exp.slot) ||
              (rsp_if.writeback !== exp.writeback) ||
              (rsp_if.writeback_addr !== exp.writeback_addr) ||
              (rsp_if.unpinned_count !== exp.unpinned_count);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp st=%0d slot=%0d wb=%0d wba=%h unp=%0d",
                     exp.status, exp.slot, exp.writeback, exp.writeback_addr,
                     exp.unpinned_count);
            $display("          got st=%0d slot=%0d wb=%0d wba=%h unp=%0d",
                     rsp_if.status, rsp_if.slot, rsp_if.writeback,
                     rsp_if.writeback_addr, rsp_if.unpinned_count);
          end
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (rst_ni === 1'b1) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.func        <= FUNC_GET;
    req_if.addr        <= 32'd0;
    req_if.file_length <= 32'd0;
    for (int i = 0; i < SLOTS; i++) begin
      tag_addr[i]   = 32'd0;
      tag_valid[i]  = 1'b0;
      tag_age[i]    = 16'd1;
      tag_pinned[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_paths();
    test_random_traffic(340);
    test_eviction_order();

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> files.f
hdl/bpr_pkg.sv
hdl/bpr_req_if.sv
hdl/bpr_rsp_if.sv
hdl/bpr_cell.sv
hdl/buffer_pool_page_replacement.sv
verif/testbench.sv
